// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh - concurrent assertion shorthands
// Implication forms used by the checker modules of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication: when a holds, c holds
`define ASSERT_IMPLY(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error(msg);

// next-cycle implication: when a holds, c holds in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error(msg);

`endif

// ----- hw/rtl/tkst_pkg.sv -----
// ----------------------------------------------------------------------------
// tkst_pkg - shared types and constants of the top-k score table
// Field widths, the neighbor link between cells and the result word layout.
// ----------------------------------------------------------------------------
package tkst_pkg;

   localparam int NAME_W  = 24;
   localparam int SCORE_W = 32;
   localparam int POS_W   = 7;
   localparam int COUNT_W = 8;

   // request kinds carried on req_tuser
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_READ   = 1'b1;

   // what one cell hands to the next one down the chain
   typedef struct packed {
      logic               ge;     // occupied and score >= incoming score
      logic [NAME_W-1:0]  name;
      logic [SCORE_W-1:0] score;
   } tkst_link_type;

   // result word, last field in the lowest bits
   typedef struct packed {
      logic [5:0]         pad;
      logic [SCORE_W-1:0] lowest_score;
      logic [COUNT_W-1:0] entry_count;
      logic               insert_kept;
      logic               entry_valid;
      logic [SCORE_W-1:0] entry_score;
      logic [NAME_W-1:0]  entry_name;
   } tkst_result_type;

   typedef enum logic {
      ST_IDLE,
      ST_PICK
   } tkst_state_type;

endpackage

// ----- hw/rtl/tkst_cell.sv -----
// ----------------------------------------------------------------------------
// tkst_cell - one rank slot of the sorted chain
// Holds one entry; on an insert it keeps its entry, takes the new one or
// takes its upper neighbor's entry, so the whole row shifts at once.
// ----------------------------------------------------------------------------
module tkst_cell (
   input  logic                         clock,
   input  logic                         insert,
   input  logic                         occupied,
   input  logic [tkst_pkg::NAME_W-1:0]  new_name,
   input  logic [tkst_pkg::SCORE_W-1:0] new_score,
   input  tkst_pkg::tkst_link_type      prev_link,
   output tkst_pkg::tkst_link_type      link
);
   import tkst_pkg::*;

   logic [NAME_W-1:0]  name_ff, name_in;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic               ge;

   // ties keep the older entry above the new one
   assign ge = occupied && (score_ff >= new_score);

   // hold, load the new entry, or shift down from the neighbor
   always_comb begin
      name_in  = name_ff;
      score_in = score_ff;
      if (insert && !ge) begin
         if (prev_link.ge) begin
            name_in  = new_name;
            score_in = new_score;
         end else begin
            name_in  = prev_link.name;
            score_in = prev_link.score;
         end
      end
   end

   always_ff @(posedge clock) begin
      name_ff  <= name_in;
      score_ff <= score_in;
   end

   assign link.ge    = ge;
   assign link.name  = name_ff;
   assign link.score = score_ff;

endmodule

// ----- hw/rtl/tkst_out_queue.sv -----
// ----------------------------------------------------------------------------
// tkst_out_queue - two-word result queue
// Lets the table take the next request while a result waits downstream.
// ----------------------------------------------------------------------------
module tkst_out_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tkst_pkg::tkst_result_type push_data,
   input  logic                      pop,
   output logic                      out_valid,
   output tkst_pkg::tkst_result_type out_data,
   output logic                      full
);
   import tkst_pkg::*;

   tkst_result_type slot_ff [2];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      fill_ff, fill_in;

   assign out_valid = (fill_ff != 2'd0);
   assign full      = (fill_ff == 2'd2);
   assign out_data  = slot_ff[rd_ptr_ff];

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/top_k_score_table.sv -----
// ----------------------------------------------------------------------------
// top_k_score_table - bounded table of entries sorted by descending score
// A row of CAPACITY cells holds the ranking; an insert compares and shifts
// every cell at once, a read selects one cell through two register stages.
//
//   channel | dir | fields
//   --------+-----+---------------------------------------------------------
//   req     | in  | tuser: mode; tdata: player_name, new_score, position
//   rsp     | out | tdata: entry_name, entry_score, entry_valid, insert_kept,
//           |     |        entry_count, lowest_score
//
// On an insert the cells compare and shift at the accepting edge and the
// result word enters the queue at that same edge.
// On a read the accepting edge registers one cell of every 16-cell group,
// the next edge moves the picked cell into the queue, and req_tready is
// low in the cycle between.
// Reset clears the entry count, the lowest score, the sequencer and the
// queue; entry contents are not cleared.
// req_tready also drops while the two-word result queue is full.
// ----------------------------------------------------------------------------
module top_k_score_table #(
   parameter int CAPACITY = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,    // [0] mode
   input  logic [63:0]  req_tdata,    // [23:0] player_name, [55:24] new_score,
                                      // [62:56] position, [63] zero
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata     // [23:0] entry_name, [55:24] entry_score,
                                      // [56] entry_valid, [57] insert_kept,
                                      // [65:58] entry_count,
                                      // [97:66] lowest_score, [103:98] zero
);
   import tkst_pkg::*;

   localparam int CW        = $clog2(CAPACITY + 1);
   localparam int PREV_LAST = (CAPACITY > 1) ? CAPACITY - 2 : 0;
   localparam int GRP_W     = 4;
   localparam int GRP_SIZE  = 1 << GRP_W;
   localparam int RD_CAP    = (CAPACITY < 128) ? CAPACITY : 128;
   localparam int RGRP      = (RD_CAP + GRP_SIZE - 1) / GRP_SIZE;
   localparam int HI_W      = (RGRP > 1) ? $clog2(RGRP) : 1;
   localparam int NGRP      = 1 << HI_W;
   localparam int PAD       = NGRP * GRP_SIZE;

   // request fields
   logic               req_mode;
   logic [NAME_W-1:0]  req_name;
   logic [SCORE_W-1:0] req_score;
   logic [POS_W-1:0]   req_pos;

   assign req_mode  = req_tuser;
   assign req_name  = req_tdata[23:0];
   assign req_score = req_tdata[55:24];
   assign req_pos   = req_tdata[62:56];

   tkst_state_type state_ff, state_in;
   logic           accept, do_insert, do_read, push_read, q_full;

   logic [CW-1:0]      count_ff, count_in;
   logic [SCORE_W-1:0] lowest_ff, lowest_in;
   logic               full, kept;

   tkst_link_type links [CAPACITY];
   tkst_link_type head_link;

   assign accept    = req_tvalid && req_tready;
   assign do_insert = accept && (req_mode == MODE_INSERT);
   assign do_read   = accept && (req_mode == MODE_READ);

   // the slot above the first cell always ranks higher
   assign head_link.ge    = 1'b1;
   assign head_link.name  = '0;
   assign head_link.score = '0;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         tkst_cell u_cell (
            .clock     (clock),
            .insert    (do_insert),
            .occupied  (CW'(gi) < count_ff),
            .new_name  (req_name),
            .new_score (req_score),
            .prev_link ((gi == 0) ? head_link : links[(gi == 0) ? 0 : gi - 1]),
            .link      (links[gi])
         );
      end
   endgenerate

   // count and lowest score after an insert
   assign full = (count_ff == CW'(CAPACITY));
   assign kept = !links[CAPACITY-1].ge;

   always_comb begin
      count_in  = count_ff;
      lowest_in = lowest_ff;
      if (do_insert && kept) begin
         if (full) begin
            if ((CAPACITY == 1) || links[PREV_LAST].ge) begin
               lowest_in = req_score;
            end else begin
               lowest_in = links[PREV_LAST].score;
            end
         end else begin
            count_in = count_ff + CW'(1);
            if ((count_ff == '0) || (lowest_ff >= req_score)) begin
               lowest_in = req_score;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         lowest_ff <= '0;
      end else begin
         count_ff  <= count_in;
         lowest_ff <= lowest_in;
      end
   end

   // read path: pad the cell row to whole groups
   logic [NAME_W-1:0]  rd_name  [PAD];
   logic [SCORE_W-1:0] rd_score [PAD];

   generate
      for (gi = 0; gi < PAD; gi++) begin : g_pad
         if (gi < CAPACITY) begin : g_used
            assign rd_name[gi]  = links[gi].name;
            assign rd_score[gi] = links[gi].score;
         end else begin : g_empty
            assign rd_name[gi]  = '0;
            assign rd_score[gi] = '0;
         end
      end
   endgenerate

   // first stage: pick the same offset in every group
   logic [NAME_W-1:0]  grp_name_ff  [NGRP];
   logic [SCORE_W-1:0] grp_score_ff [NGRP];
   logic [HI_W-1:0]    rd_hi_ff;
   logic               rd_valid_ff;
   logic               rd_valid_in;

   assign rd_valid_in = ((CW + 1)'(req_pos) < (CW + 1)'(count_ff))
                        && ((CW + 1)'(req_pos) < (CW + 1)'(CAPACITY));

   generate
      for (gi = 0; gi < NGRP; gi++) begin : g_grp
         always_ff @(posedge clock) begin
            if (do_read) begin
               grp_name_ff[gi]  <= rd_name[{HI_W'(gi), req_pos[GRP_W-1:0]}];
               grp_score_ff[gi] <= rd_score[{HI_W'(gi), req_pos[GRP_W-1:0]}];
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (do_read) begin
         rd_hi_ff    <= req_pos[GRP_W +: HI_W];
         rd_valid_ff <= rd_valid_in;
      end
   end

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (do_read) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_tready = 1'b0;
      push_read  = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = !q_full;
         ST_PICK: push_read  = 1'b1;
         default: begin
            req_tready = 1'b0;
            push_read  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // build the result word
   tkst_result_type push_word, out_word;

   always_comb begin
      push_word              = '0;
      push_word.entry_count  = COUNT_W'(count_in);
      push_word.lowest_score = lowest_in;
      if (push_read) begin
         push_word.entry_valid = rd_valid_ff;
         if (rd_valid_ff) begin
            push_word.entry_name  = grp_name_ff[rd_hi_ff];
            push_word.entry_score = grp_score_ff[rd_hi_ff];
         end
      end else begin
         push_word.insert_kept = kept;
      end
   end

   tkst_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (do_insert || push_read),
      .push_data (push_word),
      .pop       (rsp_tvalid && rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (out_word),
      .full      (q_full)
   );

   assign rsp_tdata = out_word;

endmodule

// ----- hw/rtl/tkst_checker.sv -----
// ----------------------------------------------------------------------------
// tkst_checker - port-level checks of the top-k score table
// Watches the result channel for word consistency and stall behavior.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tkst_checker #(
   parameter int CAPACITY = 128
) (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata
);
   logic [23:0] e_name;
   logic [31:0] e_score;
   logic        e_valid;
   logic        e_kept;
   logic [7:0]  e_count;
   logic [31:0] e_lowest;

   assign e_name   = rsp_tdata[23:0];
   assign e_score  = rsp_tdata[55:24];
   assign e_valid  = rsp_tdata[56];
   assign e_kept   = rsp_tdata[57];
   assign e_count  = rsp_tdata[65:58];
   assign e_lowest = rsp_tdata[97:66];

   // a word is either a read hit or an insert report, never both
   `ASSERT_IMPLY(a_read_or_insert, clock, reset, rsp_tvalid,
      !(e_valid && e_kept), "read hit and insert report in one word")

   // a miss or an insert carries no entry
   `ASSERT_IMPLY(a_empty_entry, clock, reset, rsp_tvalid && !e_valid,
      (e_name == 24'd0) && (e_score == 32'd0), "entry fields set without a hit")

   // a hit never ranks below the bottom of the table, and the count fits
   `ASSERT_IMPLY(a_hit_ranked, clock, reset, rsp_tvalid && e_valid,
      (e_score >= e_lowest) && (e_count != 8'd0)
      && ((CAPACITY >= 256) || (e_count <= CAPACITY)), "hit outside table order")

   // a stalled word holds
   `ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "result word changed under stall")

endmodule

bind top_k_score_table tkst_checker #(.CAPACITY(CAPACITY)) u_tkst_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/tkst_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkst_scoreboard - scoreboard for the top-k score table
// Watches the req and rsp channels, keeps its own sorted ranking of names
// and scores, predicts one result word per accepted request and compares
// every accepted rsp word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tkst_scoreboard #(
   parameter int CAPACITY = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic         req_tuser,      // [0] mode
   input  logic [63:0]  req_tdata,      // player_name, new_score, position, zero
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,      // entry_name, entry_score, entry_valid,
                                        // insert_kept, entry_count, lowest_score
   output int           fail_count,
   output int           pending_count,
   output int           kept_count,
   output int           dropped_count,
   output int           hit_count,
   output int           miss_count,
   output int           peak_fill
);
   import tkst_pkg::*;

   // shadow ranking, highest score first, oldest first among equal scores
   logic [NAME_W-1:0]  rank_name  [CAPACITY];
   logic [SCORE_W-1:0] rank_score [CAPACITY];
   int                 rank_fill;

   tkst_result_type    expected_words [$];

   // apply one request to the shadow ranking and return the word it must cause
   function automatic tkst_result_type rank_update(input logic mode, input logic [63:0] data);
      tkst_result_type    res;
      logic [NAME_W-1:0]  nm;
      logic [SCORE_W-1:0] sc;
      logic [POS_W-1:0]   pos;
      int                 slot;
      int                 last;
      int                 i;
      res = '0;
      nm  = data[NAME_W-1:0];
      sc  = data[NAME_W +: SCORE_W];
      pos = data[NAME_W+SCORE_W +: POS_W];
      if (mode == MODE_INSERT) begin
         // land after every entry with an equal or higher score
         slot = 0;
         while (slot < rank_fill && rank_score[slot] >= sc) slot++;
         if (slot < CAPACITY) begin
            last = (rank_fill < CAPACITY) ? rank_fill : CAPACITY - 1;
            for (i = last; i > slot; i--) begin
               rank_name[i]  = rank_name[i-1];
               rank_score[i] = rank_score[i-1];
            end
            rank_name[slot]  = nm;
            rank_score[slot] = sc;
            if (rank_fill < CAPACITY) rank_fill++;
            res.insert_kept = 1'b1;
         end
      end else if (pos < rank_fill) begin
         res.entry_name  = rank_name[pos];
         res.entry_score = rank_score[pos];
         res.entry_valid = 1'b1;
      end
      res.entry_count = COUNT_W'(rank_fill);
      if (rank_fill > 0) res.lowest_score = rank_score[rank_fill-1];
      return res;
   endfunction

   task automatic check_field(input string field, input logic [SCORE_W-1:0] want,
                              input logic [SCORE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: rsp %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field, want, got);
         fail_count++;
      end
   endtask

   initial begin
      fail_count    = 0;
      pending_count = 0;
      kept_count    = 0;
      dropped_count = 0;
      hit_count     = 0;
      miss_count    = 0;
      peak_fill     = 0;
      rank_fill     = 0;
   end

   // sample both channels on the rising edge
   always @(posedge clock) begin : watch
      tkst_result_type want;
      tkst_result_type got;
      if (reset) begin
         rank_fill = 0;
         expected_words.delete();
      end else begin
         // compare an accepted result word with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_words.size() == 0) begin
               $display("%0t: rsp word with nothing expected, actual 0x%0h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("entry_name",   want.entry_name,   got.entry_name);
               check_field("entry_score",  want.entry_score,  got.entry_score);
               check_field("entry_valid",  want.entry_valid,  got.entry_valid);
               check_field("insert_kept",  want.insert_kept,  got.insert_kept);
               check_field("entry_count",  want.entry_count,  got.entry_count);
               check_field("lowest_score", want.lowest_score, got.lowest_score);
               check_field("pad",          want.pad,          got.pad);
            end
         end
         // predict the word for an accepted request
         if (req_tvalid && req_tready) begin
            want = rank_update(req_tuser, req_tdata);
            expected_words.push_back(want);
            if (req_tuser == MODE_INSERT) begin
               if (want.insert_kept) kept_count++;
               else dropped_count++;
            end else begin
               if (want.entry_valid) hit_count++;
               else miss_count++;
            end
            if (rank_fill > peak_fill) peak_fill = rank_fill;
         end
      end
      pending_count = expected_words.size();
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the top-k score table
// Drives directed and random insert and read words in bursts while the
// result side stalls on its own pattern, with long hold-offs that back the
// table up; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;
   import tkst_pkg::*;

   localparam int CAPACITY   = 128;
   localparam int ITEM_COUNT = 900;
   localparam int HOLD_LEN   = 300;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic         req_tuser;     // [0] mode
   logic [63:0]  req_tdata;     // [23:0] player_name, [55:24] new_score,
                                // [62:56] position, [63] zero
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;     // [23:0] entry_name, [55:24] entry_score,
                                // [56] entry_valid, [57] insert_kept,
                                // [65:58] entry_count, [97:66] lowest_score

   int           fail_count;
   int           pending_count;
   int           kept_count;
   int           dropped_count;
   int           hit_count;
   int           miss_count;
   int           peak_fill;
   int           words_sent;

   top_k_score_table #(
      .CAPACITY   (CAPACITY)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   tkst_scoreboard #(
      .CAPACITY      (CAPACITY)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tuser     (req_tuser),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .kept_count    (kept_count),
      .dropped_count (dropped_count),
      .hit_count     (hit_count),
      .miss_count    (miss_count),
      .peak_fill     (peak_fill)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // offer one word at a falling edge, hold it until taken
   task automatic send_word(input logic mode, input logic [NAME_W-1:0] nm,
                            input logic [SCORE_W-1:0] sc, input logic [POS_W-1:0] pos);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {1'b0, pos, sc, nm};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   // pick a score that keeps ties frequent near the bottom of the table
   function automatic logic [SCORE_W-1:0] pick_score();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 7) return '0;
      if (roll < 12) return '1;
      if (roll < 20) return $urandom;
      return $urandom_range(1, 60);
   endfunction

   // stimulus
   initial begin : stimulus
      int burst;
      int gap;
      int n;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = MODE_INSERT;
      req_tdata  = '0;
      words_sent = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table, extremes, ties at the top and in the middle
      send_word(MODE_READ,   24'h000000, 32'h0, 7'd0);
      send_word(MODE_READ,   24'hFFFFFF, 32'hFFFF_FFFF, 7'd127);
      send_word(MODE_INSERT, 24'hFFFFFF, 32'hFFFF_FFFF, 7'd0);
      send_word(MODE_INSERT, 24'h000000, 32'h0, 7'd127);
      send_word(MODE_INSERT, 24'h314241, 32'd1000, 7'd0);
      send_word(MODE_INSERT, 24'h324241, 32'd1000, 7'd0);
      send_word(MODE_INSERT, 24'h414141, 32'hFFFF_FFFF, 7'd0);
      send_word(MODE_INSERT, 24'h5A5A5A, 32'd1, 7'd0);
      send_word(MODE_INSERT, 24'h303030, 32'h0, 7'd0);
      for (n = 0; n < 8; n++) send_word(MODE_READ, NAME_W'($urandom), $urandom, POS_W'(n));
      send_word(MODE_READ, 24'h0, 32'h0, 7'd127);

      // random words in bursts; the table fills and then drops low inserts
      n = 0;
      while (n < ITEM_COUNT) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
         if (burst > ITEM_COUNT - n) burst = ITEM_COUNT - n;
         repeat (burst) begin
            if ($urandom_range(0, 9) < 4)
               send_word(MODE_READ, NAME_W'($urandom), $urandom,
                         $urandom_range(0, 1) ? POS_W'($urandom_range(0, 127))
                                              : POS_W'($urandom_range(0, 15)));
            else
               send_word(MODE_INSERT, NAME_W'($urandom), pick_score(), POS_W'($urandom));
            n++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 1'b0;

      // drain, then let any stray word show up
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d kept and %0d dropped inserts, %0d reads in range, %0d past the count",
               kept_count, dropped_count, hit_count, miss_count);
      $display("table reached %0d of %0d entries", peak_fill, CAPACITY);
      if (fail_count == 0 && pending_count == 0)
         $display("PASS top_k_score_table");
      else
         $display("FAIL top_k_score_table");
      $finish;
   end

   // result side: stall on changing patterns, hold off for long stretches twice
   initial begin : receiver
      logic [31:0] pattern;
      int          k;
      int          hold_mark;
      rsp_tready = 1'b0;
      hold_mark  = 300;
      forever begin
         if (hold_mark > 0 && words_sent >= hold_mark) begin
            hold_mark = (hold_mark < 700) ? 700 : 0;
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (HOLD_LEN - 1) @(negedge clock);
         end
         case ($urandom_range(0, 3))
            0:       pattern = '1;
            1:       pattern = $urandom;
            2:       pattern = $urandom | $urandom;
            default: pattern = $urandom & $urandom;
         endcase
         for (k = 0; k < 32; k++) begin
            @(negedge clock);
            rsp_tready <= pattern[k];
         end
      end
   end

   // overall time limit
   initial begin : watchdog
      #5_000_000;
      $display("FAIL top_k_score_table");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/tkst_pkg.sv
hw/rtl/tkst_cell.sv
hw/rtl/tkst_out_queue.sv
hw/rtl/top_k_score_table.sv
hw/rtl/tkst_checker.sv
tb/tkst_checker.sv
tb/tb_top.sv
